// ----- hdl/dsw_pkg.sv -----
// Shared widths, constants, types and helpers for the two-wheel body velocity block.
package dsw_pkg;

   // Fixed field and datapath widths.
   localparam int SPEED_W = 16;
   localparam int POS_W   = 16;
   localparam int TRIG_W  = 34;
   localparam int Z_W     = 33;
   localparam int PROD_W  = 50;
   localparam int PART_W  = 26;
   localparam int NUM_W   = 39;
   localparam int DEN_W   = 17;
   localparam int OM_W    = 40;
   localparam int OM_LO_W = 20;
   localparam int ACC_W   = 58;

   // CORDIC gain and arctangent table, Q2.30 and full-turn angle units.
   localparam int TABLE_LEN = 24;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef enum logic [1:0] {
      MODE_X_SEP      = 2'd0,
      MODE_Y_SEP      = 2'd1,
      MODE_COINCIDENT = 2'd2
   } layout_mode_type;

   typedef enum logic [1:0] {
      CSR_A_POS_X = 2'd0,
      CSR_A_POS_Y = 2'd1,
      CSR_B_POS_X = 2'd2,
      CSR_B_POS_Y = 2'd3
   } csr_index_type;

   // Data that travels beside the divider.
   typedef struct packed {
      logic signed [PART_W-1:0] ax;
      logic signed [PART_W-1:0] ay;
      logic signed [PART_W-1:0] bx;
      logic signed [PART_W-1:0] by;
      layout_mode_type          mode;
      logic                     neg;
   } div_side_type;

   // Clamp a wide signed value to the 16-bit output range.
   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (v > ACC_W'(32767)) begin
         r = 16'sh7fff;
      end else if (v < ACC_W'(-32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/dsw_if.sv -----
// Request and response channel interfaces.
interface dsw_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] speed_a;
   logic signed [15:0] steer_a;
   logic signed [15:0] speed_b;
   logic signed [15:0] steer_b;

   modport source(output valid, speed_a, steer_a, speed_b, steer_b, input ready);
   modport sink(input valid, speed_a, steer_a, speed_b, steer_b, output ready);
endinterface

interface dsw_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] body_vel_x;
   logic signed [15:0] body_vel_y;
   logic signed [15:0] yaw_rate;
   logic [1:0]         layout_mode;

   modport source(output valid, body_vel_x, body_vel_y, yaw_rate, layout_mode, input ready);
   modport sink(input valid, body_vel_x, body_vel_y, yaw_rate, layout_mode, output ready);
endinterface

// ----- hdl/dual_steered_wheel_body_velocity_top.sv -----
// Two steered wheels to body velocity and yaw rate: top level with the arithmetic stages.
// Throughput: one transfer per cycle; the CORDIC and divider pipelines take a new item each cycle.
// A response not taken holds the whole pipeline and the request side waits with it.
// Reset is synchronous and active high: it clears the stage valid bits and the wheel positions.
// The user must write wheel positions only while the pipeline is empty; the block does not enforce this.
module dual_steered_wheel_body_velocity_top
   import dsw_pkg::*;
#(
   parameter int ANGLE_BITS      = 16,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   dsw_req_if.sink            req_if,
   dsw_rsp_if.source          rsp_if,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [POS_W-1:0]   csr_wr_data
);

   logic advance;

   logic signed [POS_W-1:0] pos_ax_ff, pos_ay_ff, pos_bx_ff, pos_by_ff;

   logic               s0_vld_ff;
   logic signed [15:0] s0_spd_a_ff, s0_steer_a_ff, s0_spd_b_ff, s0_steer_b_ff;

   logic                     ca_vld, cb_vld;
   logic signed [TRIG_W-1:0] ca_cos, ca_sin, cb_cos, cb_sin;
   logic signed [15:0]       ca_spd, cb_spd;

   logic                     m1_vld_ff, m2_vld_ff, m3_vld_ff;
   logic signed [PROD_W-1:0] m1_pax_ff, m1_pay_ff, m1_pbx_ff, m1_pby_ff;
   logic signed [PROD_W-1:0] m2_rax, m2_ray, m2_rbx, m2_rby;
   logic signed [PART_W-1:0] m2_ax_ff, m2_ay_ff, m2_bx_ff, m2_by_ff;

   logic signed [DEN_W-1:0]   dx, dy, den_s;
   logic signed [PART_W:0]    diff_s;
   logic signed [NUM_W-1:0]   num_s;
   logic [NUM_W-1:0]          num_mag;
   logic [DEN_W-1:0]          den_mag;
   layout_mode_type           mode_in;
   div_side_type              side_in;
   logic [NUM_W-1:0]          m3_num_ff;
   logic [DEN_W-1:0]          m3_den_ff;
   div_side_type              m3_side_ff;

   logic                      dv_vld;
   logic [NUM_W-1:0]          dv_quot;
   div_side_type              dv_side;

   logic                      d1_vld_ff;
   logic signed [OM_W-1:0]    d1_om_ff;
   div_side_type              d1_side_ff;

   logic signed [DEN_W-1:0]   sum_x_pos, sum_y_pos;
   logic                      c1_vld_ff, c2_vld_ff, c3_vld_ff;
   logic signed [37:0]        c1_plx_ff, c1_ply_ff;
   logic signed [36:0]        c1_phx_ff, c1_phy_ff;
   logic signed [PART_W:0]    c1_sumx_ff, c1_sumy_ff, c2_sumx_ff, c2_sumy_ff;
   logic signed [OM_W-1:0]    c1_om_ff, c2_om_ff;
   layout_mode_type           c1_mode_ff, c2_mode_ff, c3_mode_ff;
   logic signed [ACC_W-1:0]   c2_prodx_ff, c2_prody_ff;
   logic signed [ACC_W-1:0]   accx, accy, rndx, rndy, rndw;
   logic signed [ACC_W-1:0]   vx_in, vy_in, yaw_in;
   logic signed [ACC_W-1:0]   c3_vx_ff, c3_vy_ff, c3_yaw_ff;

   logic                      out_vld_ff;
   logic signed [15:0]        out_vx_ff, out_vy_ff, out_yaw_ff;
   layout_mode_type           out_mode_ff;

   // The whole pipeline moves while the response register is free or being taken.
   assign advance      = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // Wheel position registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ax_ff <= '0;
         pos_ay_ff <= '0;
         pos_bx_ff <= '0;
         pos_by_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_A_POS_X: pos_ax_ff <= csr_wr_data;
            CSR_A_POS_Y: pos_ay_ff <= csr_wr_data;
            CSR_B_POS_X: pos_bx_ff <= csr_wr_data;
            CSR_B_POS_Y: pos_by_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Valid bits of the stages in this module.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         d1_vld_ff  <= 1'b0;
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         c3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s0_vld_ff  <= req_if.valid;
         m1_vld_ff  <= ca_vld;
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         d1_vld_ff  <= dv_vld;
         c1_vld_ff  <= d1_vld_ff;
         c2_vld_ff  <= c1_vld_ff;
         c3_vld_ff  <= c2_vld_ff;
         out_vld_ff <= c3_vld_ff;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_spd_a_ff   <= req_if.speed_a;
         s0_steer_a_ff <= req_if.steer_a;
         s0_spd_b_ff   <= req_if.speed_b;
         s0_steer_b_ff <= req_if.steer_b;
      end
   end

   dsw_cordic #(.ANGLE_BITS(ANGLE_BITS), .ITERS(TRIG_ITERATIONS)) u_cordic_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_vld_ff),
      .in_angle  (s0_steer_a_ff),
      .in_speed  (s0_spd_a_ff),
      .out_valid (ca_vld),
      .out_cos   (ca_cos),
      .out_sin   (ca_sin),
      .out_speed (ca_spd)
   );

   dsw_cordic #(.ANGLE_BITS(ANGLE_BITS), .ITERS(TRIG_ITERATIONS)) u_cordic_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_vld_ff),
      .in_angle  (s0_steer_b_ff),
      .in_speed  (s0_spd_b_ff),
      .out_valid (cb_vld),
      .out_cos   (cb_cos),
      .out_sin   (cb_sin),
      .out_speed (cb_spd)
   );

   // Speed times cosine and sine for each wheel.
   always_ff @(posedge clock) begin
      if (advance) begin
         m1_pax_ff <= PROD_W'(ca_spd) * PROD_W'(ca_cos);
         m1_pay_ff <= PROD_W'(ca_spd) * PROD_W'(ca_sin);
         m1_pbx_ff <= PROD_W'(cb_spd) * PROD_W'(cb_cos);
         m1_pby_ff <= PROD_W'(cb_spd) * PROD_W'(cb_sin);
      end
   end

   // Round the wheel parts to 2^-16 m/s, half up.
   always_comb begin
      m2_rax = m1_pax_ff + PROD_W'(2097152);
      m2_ray = m1_pay_ff + PROD_W'(2097152);
      m2_rbx = m1_pbx_ff + PROD_W'(2097152);
      m2_rby = m1_pby_ff + PROD_W'(2097152);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_ax_ff <= m2_rax[PART_W+21:22];
         m2_ay_ff <= m2_ray[PART_W+21:22];
         m2_bx_ff <= m2_rbx[PART_W+21:22];
         m2_by_ff <= m2_rby[PART_W+21:22];
      end
   end

   // Pick the layout, then form the divider operands as magnitudes with a sign.
   always_comb begin
      dx = DEN_W'(pos_ax_ff) - DEN_W'(pos_bx_ff);
      dy = DEN_W'(pos_ay_ff) - DEN_W'(pos_by_ff);
      if (dx != '0) begin
         mode_in = MODE_X_SEP;
      end else if (dy != '0) begin
         mode_in = MODE_Y_SEP;
      end else begin
         mode_in = MODE_COINCIDENT;
      end
      unique case (mode_in)
         MODE_X_SEP: begin
            diff_s = (PART_W+1)'(m2_ay_ff) - (PART_W+1)'(m2_by_ff);
            den_s  = dx;
         end
         MODE_Y_SEP: begin
            diff_s = (PART_W+1)'(m2_bx_ff) - (PART_W+1)'(m2_ax_ff);
            den_s  = dy;
         end
         default: begin
            diff_s = '0;
            den_s  = '0;
         end
      endcase
      num_s   = {diff_s, 12'h000};
      num_mag = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
      den_mag = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
      side_in.ax   = m2_ax_ff;
      side_in.ay   = m2_ay_ff;
      side_in.bx   = m2_bx_ff;
      side_in.by   = m2_by_ff;
      side_in.mode = mode_in;
      side_in.neg  = num_s[NUM_W-1] ^ den_s[DEN_W-1];
   end

   // Adding half the divisor gives rounding to nearest, ties away from zero.
   always_ff @(posedge clock) begin
      if (advance) begin
         m3_num_ff  <= num_mag + NUM_W'(den_mag >> 1);
         m3_den_ff  <= den_mag;
         m3_side_ff <= side_in;
      end
   end

   dsw_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m3_vld_ff),
      .in_num    (m3_num_ff),
      .in_den    (m3_den_ff),
      .in_side   (m3_side_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // Signed yaw rate in 2^-16 rad/s; zero when the wheels coincide.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (dv_side.mode == MODE_COINCIDENT) begin
            d1_om_ff <= '0;
         end else if (dv_side.neg) begin
            d1_om_ff <= -signed'({1'b0, dv_quot});
         end else begin
            d1_om_ff <= signed'({1'b0, dv_quot});
         end
         d1_side_ff <= dv_side;
      end
   end

   // Rigid-body correction: yaw rate times position sums, split into two partial products.
   always_comb begin
      sum_x_pos = DEN_W'(pos_ax_ff) + DEN_W'(pos_bx_ff);
      sum_y_pos = DEN_W'(pos_ay_ff) + DEN_W'(pos_by_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_plx_ff  <= 38'(signed'({1'b0, d1_om_ff[OM_LO_W-1:0]})) * 38'(sum_y_pos);
         c1_ply_ff  <= 38'(signed'({1'b0, d1_om_ff[OM_LO_W-1:0]})) * 38'(sum_x_pos);
         c1_phx_ff  <= 37'(signed'(d1_om_ff[OM_W-1:OM_LO_W])) * 37'(sum_y_pos);
         c1_phy_ff  <= 37'(signed'(d1_om_ff[OM_W-1:OM_LO_W])) * 37'(sum_x_pos);
         c1_sumx_ff <= (PART_W+1)'(d1_side_ff.ax) + (PART_W+1)'(d1_side_ff.bx);
         c1_sumy_ff <= (PART_W+1)'(d1_side_ff.ay) + (PART_W+1)'(d1_side_ff.by);
         c1_om_ff   <= d1_om_ff;
         c1_mode_ff <= d1_side_ff.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2_prodx_ff <= (ACC_W'(c1_phx_ff) <<< OM_LO_W) + ACC_W'(c1_plx_ff);
         c2_prody_ff <= (ACC_W'(c1_phy_ff) <<< OM_LO_W) + ACC_W'(c1_ply_ff);
         c2_sumx_ff  <= c1_sumx_ff;
         c2_sumy_ff  <= c1_sumy_ff;
         c2_om_ff    <= c1_om_ff;
         c2_mode_ff  <= c1_mode_ff;
      end
   end

   // Final sums and rounding to Q8.8, half up.
   always_comb begin
      accx = (ACC_W'(c2_sumx_ff) <<< 12) + c2_prodx_ff;
      accy = (ACC_W'(c2_sumy_ff) <<< 12) - c2_prody_ff;
      rndw = ACC_W'(c2_om_ff) + ACC_W'(128);
      yaw_in = ACC_W'(signed'(rndw[ACC_W-1:8]));
      if (c2_mode_ff == MODE_X_SEP) begin
         rndx  = accx + ACC_W'(1048576);
         rndy  = accy + ACC_W'(1048576);
         vx_in = ACC_W'(signed'(rndx[ACC_W-1:21]));
         vy_in = ACC_W'(signed'(rndy[ACC_W-1:21]));
      end else begin
         rndx  = ACC_W'(c2_sumx_ff) + ACC_W'(256);
         rndy  = ACC_W'(c2_sumy_ff) + ACC_W'(256);
         vx_in = ACC_W'(signed'(rndx[ACC_W-1:9]));
         vy_in = ACC_W'(signed'(rndy[ACC_W-1:9]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_vx_ff   <= vx_in;
         c3_vy_ff   <= vy_in;
         c3_yaw_ff  <= yaw_in;
         c3_mode_ff <= c2_mode_ff;
      end
   end

   // Saturating response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_vx_ff   <= sat16(c3_vx_ff);
         out_vy_ff   <= sat16(c3_vy_ff);
         out_yaw_ff  <= sat16(c3_yaw_ff);
         out_mode_ff <= c3_mode_ff;
      end
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.body_vel_x  = out_vx_ff;
   assign rsp_if.body_vel_y  = out_vy_ff;
   assign rsp_if.yaw_rate    = out_yaw_ff;
   assign rsp_if.layout_mode = out_mode_ff;

`ifndef SYNTH
   // Both trig lanes carry the same item at the same time.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      ca_vld == cb_vld)
      else $error("CORDIC lanes out of step");

   // Coincident wheels never report a yaw rate.
   a_coincident_no_yaw: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_mode_ff == MODE_COINCIDENT)) |-> (out_yaw_ff == 16'sd0))
      else $error("yaw rate reported for coincident wheels");

   // The y-separated layout only arises when the x positions agree.
   a_y_mode_x_equal: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_mode_ff == MODE_Y_SEP)) |-> (pos_ax_ff == pos_bx_ff))
      else $error("y layout with differing x positions");

   // A stalled response keeps the pipeline frozen for the next cycle.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_if.ready) |=> ($stable(c3_vx_ff) && $stable(d1_om_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule

// ----- hdl/dsw_cordic.sv -----
// Pipelined CORDIC sine and cosine, one iteration per stage, with the wheel speed alongside.
module dsw_cordic
   import dsw_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int ITERS      = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [15:0]       in_angle,
   input  logic signed [15:0]       in_speed,
   output logic                     out_valid,
   output logic signed [TRIG_W-1:0] out_cos,
   output logic signed [TRIG_W-1:0] out_sin,
   output logic signed [15:0]       out_speed
);

   localparam int DROP = 32 - ANGLE_BITS;
   localparam logic [31:0] ANGLE_MASK = ~((32'd1 << DROP) - 32'd1);

   logic [31:0]            turn;
   logic                   flip_start;
   logic signed [Z_W-1:0]  z_start;

   logic                     vld_ff   [ITERS];
   logic signed [TRIG_W-1:0] x_ff     [ITERS];
   logic signed [TRIG_W-1:0] y_ff     [ITERS];
   logic signed [Z_W-1:0]    z_ff     [ITERS];
   logic                     flip_ff  [ITERS];
   logic signed [15:0]       spd_ff   [ITERS];

   logic                     out_vld_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [15:0]       spd_out_ff;

   // Fold the angle into the right half plane; a fold negates the results.
   always_comb begin
      turn = {in_angle, 16'h0000} & ANGLE_MASK;
      flip_start = (turn[31:30] == 2'b10) || ((turn[31:30] == 2'b01) && (turn[29:0] != '0));
      z_start = flip_start ? Z_W'(signed'(turn ^ 32'h8000_0000)) : Z_W'(signed'(turn));
   end

   for (genvar i = 0; i < ITERS; i++) begin : g_iter
      logic                     vld_prev;
      logic signed [TRIG_W-1:0] x_prev;
      logic signed [TRIG_W-1:0] y_prev;
      logic signed [Z_W-1:0]    z_prev;
      logic                     flip_prev;
      logic signed [15:0]       spd_prev;
      logic signed [TRIG_W-1:0] x_in;
      logic signed [TRIG_W-1:0] y_in;
      logic signed [Z_W-1:0]    z_in;
      logic signed [Z_W-1:0]    atan_val;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign x_prev    = CORDIC_GAIN;
         assign y_prev    = '0;
         assign z_prev    = z_start;
         assign flip_prev = flip_start;
         assign spd_prev  = in_speed;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign flip_prev = flip_ff[i-1];
         assign spd_prev  = spd_ff[i-1];
      end

      assign atan_val = signed'({1'b0, ATAN_TABLE[i]});

      // One micro-rotation towards zero residual angle.
      always_comb begin
         if (!z_prev[Z_W-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - atan_val;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + atan_val;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            flip_ff[i] <= flip_prev;
            spd_ff[i]  <= spd_prev;
         end
      end
   end

   // Undo the fold on the way out.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[ITERS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff     <= flip_ff[ITERS-1] ? -x_ff[ITERS-1] : x_ff[ITERS-1];
         sin_ff     <= flip_ff[ITERS-1] ? -y_ff[ITERS-1] : y_ff[ITERS-1];
         spd_out_ff <= spd_ff[ITERS-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_speed = spd_out_ff;

endmodule

// ----- hdl/dsw_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data alongside.
module dsw_divider
   import dsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  div_side_type     in_side,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output div_side_type     out_side
);

   logic               vld_ff  [NUM_W];
   logic [DEN_W-1:0]   rem_ff  [NUM_W];
   logic [NUM_W-1:0]   num_ff  [NUM_W];
   logic [NUM_W-1:0]   quot_ff [NUM_W];
   logic [DEN_W-1:0]   den_ff  [NUM_W];
   div_side_type       side_ff [NUM_W];

   for (genvar j = 0; j < NUM_W; j++) begin : g_bit
      logic             vld_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] num_prev;
      logic [NUM_W-1:0] quot_prev;
      logic [DEN_W-1:0] den_prev;
      div_side_type     side_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign num_prev  = in_num;
         assign quot_prev = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign num_prev  = num_ff[j-1];
         assign quot_prev = quot_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // Bring down the next dividend bit and try a subtraction.
      always_comb begin
         trial = {rem_prev, num_prev[NUM_W-1]};
         diff  = trial - {1'b0, den_prev};
         take  = (trial >= {1'b0, den_prev});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (advance) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_ff[j]  <= {num_prev[NUM_W-2:0], 1'b0};
            quot_ff[j] <= {quot_prev[NUM_W-2:0], take};
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ----- bench/dsw_tb_if.sv -----
// Testbench types for one set of wheel readings and one body velocity result.
package dsw_tb_types;
   timeunit 1ns;
   timeprecision 1ps;

   // One set of wheel readings as presented on the request channel.
   typedef struct packed {
      logic signed [15:0] speed_a;
      logic signed [15:0] steer_a;
      logic signed [15:0] speed_b;
      logic signed [15:0] steer_b;
   } wheel_sample_type;

   // One body velocity result.
   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] yaw;
      logic [1:0]         mode;
   } body_motion_type;
endpackage

// ----- bench/dual_steered_wheel_body_velocity_top_tb.sv -----
// Testbench for the two-wheel body velocity block: directed and random wheel samples against a predictor.
module dual_steered_wheel_body_velocity_top_tb
   import dsw_pkg::*, dsw_tb_types::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS = 16;
   localparam int TRIG_ITERATIONS = 16;
   localparam int LATENCY = TRIG_ITERATIONS + 49;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1250;

   // Arctangent steps in full-turn units.
   localparam longint ATAN_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   // Kinematics predictor and the queue of expected body motions.
   class body_motion_board;
      longint wheel_pos [4];
      body_motion_type pending [$];
      int errors;

      function new();
         foreach (wheel_pos[i]) wheel_pos[i] = 0;
         errors = 0;
      endfunction

      function void set_position(csr_index_type idx, logic [15:0] value);
         wheel_pos[idx] = longint'($signed(value));
      endfunction

      static function longint floor_div_pow2(longint v, int s);
         return v >>> s;
      endfunction

      static function longint round_half_up(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      static function longint div_nearest(longint n, longint d);
         longint un, ud, q;
         if (d == 0) return 0;
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         q = (un + ud / 2) / ud;
         return ((n < 0) != (d < 0)) ? -q : q;
      endfunction

      static function logic [15:0] clamp16(longint v);
         if (v > 32767) return 16'h7fff;
         if (v < -32768) return 16'h8000;
         return v[15:0];
      endfunction

      // CORDIC cosine and sine in Q2.30 of a binary angle.
      static function void cos_sin(logic [15:0] angle, output longint c, output longint s);
         logic [31:0] word;
         longint z, x, y, xs, ys;
         bit flip;
         int drop;
         drop = 32 - ANGLE_BITS;
         word = {angle, 16'h0000};
         word = word & ~((32'd1 << drop) - 32'd1);
         z = longint'($signed(word));
         flip = 0;
         if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
         end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
         end
         x = 652032874;
         y = 0;
         for (int i = 0; i < TRIG_ITERATIONS; i++) begin
            xs = floor_div_pow2(y, i);
            ys = floor_div_pow2(x, i);
            if (z >= 0) begin
               x -= xs;
               y += ys;
               z -= ATAN_STEP[i];
            end else begin
               x += xs;
               y -= ys;
               z += ATAN_STEP[i];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      // Work out the body motion that one sample set gives.
      function void note_sample(wheel_sample_type w);
         longint ca, sa, cb, sb, ax, ay, bx, by, dx, dy, om, vx, vy;
         body_motion_type r;
         cos_sin(w.steer_a, ca, sa);
         cos_sin(w.steer_b, cb, sb);
         ax = round_half_up(longint'(w.speed_a) * ca, 22);
         ay = round_half_up(longint'(w.speed_a) * sa, 22);
         bx = round_half_up(longint'(w.speed_b) * cb, 22);
         by = round_half_up(longint'(w.speed_b) * sb, 22);
         dx = wheel_pos[CSR_A_POS_X] - wheel_pos[CSR_B_POS_X];
         dy = wheel_pos[CSR_A_POS_Y] - wheel_pos[CSR_B_POS_Y];
         om = 0;
         if (dx != 0) begin
            r.mode = MODE_X_SEP;
            om = div_nearest((ay - by) * 4096, dx);
            vx = round_half_up((ax + bx) * 4096
                 + om * (wheel_pos[CSR_A_POS_Y] + wheel_pos[CSR_B_POS_Y]), 21);
            vy = round_half_up((ay + by) * 4096
                 - om * (wheel_pos[CSR_A_POS_X] + wheel_pos[CSR_B_POS_X]), 21);
         end else begin
            r.mode = (dy != 0) ? MODE_Y_SEP : MODE_COINCIDENT;
            if (dy != 0) om = div_nearest(-(ax - bx) * 4096, dy);
            vx = round_half_up(ax + bx, 9);
            vy = round_half_up(ay + by, 9);
         end
         r.vel_x = clamp16(vx);
         r.vel_y = clamp16(vy);
         r.yaw = clamp16(round_half_up(om, 8));
         pending = {pending, r};
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(body_motion_type got);
         body_motion_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.vel_x !== want.vel_x) begin
            $display("%0t: body_vel_x expected %0d actual %0d", $time, want.vel_x, got.vel_x);
            errors++;
         end
         if (got.vel_y !== want.vel_y) begin
            $display("%0t: body_vel_y expected %0d actual %0d", $time, want.vel_y, got.vel_y);
            errors++;
         end
         if (got.yaw !== want.yaw) begin
            $display("%0t: yaw_rate expected %0d actual %0d", $time, want.yaw, got.yaw);
            errors++;
         end
         if (got.mode !== want.mode) begin
            $display("%0t: layout_mode expected %0d actual %0d", $time, want.mode, got.mode);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wr_data = '0;
   bit quiet_phase = 0;
   int idle_cycles = 0;
   body_motion_board board;

   dsw_req_if req_if ();
   dsw_rsp_if rsp_if ();

   dual_steered_wheel_body_velocity_top #(
      .ANGLE_BITS(ANGLE_BITS),
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.speed_a = '0;
      req_if.steer_a = '0;
      req_if.speed_b = '0;
      req_if.steer_b = '0;
      rsp_if.ready = 1'b0;
      board = new();
   end

   // Note each request transfer and check each result transfer at the rising edge.
   always @(posedge clock) begin : p_monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_sample({req_if.speed_a, req_if.steer_a, req_if.speed_b,
                               req_if.steer_b});
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result({rsp_if.body_vel_x, rsp_if.body_vel_y, rsp_if.yaw_rate,
                                rsp_if.layout_mode});
            moved = 1'b1;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog on a run with no transfers.
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: ready drops in random bursts.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
         end
      end
   end

   task automatic write_position(csr_index_type idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_position(idx, value);
   endtask

   // Present one sample and hold it until the transfer.
   task automatic send_sample(wheel_sample_type w);
      req_if.valid <= 1'b1;
      req_if.speed_a <= w.speed_a;
      req_if.steer_a <= w.steer_a;
      req_if.speed_b <= w.speed_b;
      req_if.steer_b <= w.steer_b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // Mostly full-range random values, with frequent extremes and some moderate values.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 2048)) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h4000;
         2: return 16'hc000;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic wheel_sample_type random_sample();
      wheel_sample_type w;
      w.speed_a = pick_value();
      w.steer_a = pick_angle();
      w.speed_b = pick_value();
      w.steer_b = pick_angle();
      return w;
   endfunction

   // Wheel layouts: separated in x, separated only in y, coincident, and extremes.
   task automatic apply_layout(int kind);
      logic [15:0] ax, ay, bx, by;
      ax = pick_value();
      ay = pick_value();
      bx = pick_value();
      by = pick_value();
      case (kind)
         0: begin ax = 16'h7fff; bx = 16'h8000; ay = 16'h8000; by = 16'h7fff; end
         1: begin ax = 16'h0001; bx = 16'h0000; end
         2: bx = ax;
         3: begin bx = ax; by = ay; end
         4: begin ax = 16'h0000; ay = 16'h1000; bx = 16'h0000; by = 16'hf000; end
         default: ;
      endcase
      write_position(CSR_A_POS_X, ax);
      write_position(CSR_A_POS_Y, ay);
      write_position(CSR_B_POS_X, bx);
      write_position(CSR_B_POS_Y, by);
   endtask

   // Main sequence.
   initial begin
      wheel_sample_type w;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples with coincident wheels at reset, then x-separated wheels.
      for (int k = 0; k < 2; k++) begin
         if (k == 1) apply_layout(1);
         send_sample({16'h7fff, 16'h0000, 16'h8000, 16'h8000});
         send_sample({16'h8000, 16'h7fff, 16'h7fff, 16'h4000});
         send_sample({16'h0100, 16'hc000, 16'h0100, 16'h2000});
         send_sample({16'hffff, 16'h0001, 16'h0000, 16'hffff});
         send_sample({16'h7fff, 16'h4000, 16'h8000, 16'hc000});
         send_sample({16'h5555, 16'haaaa, 16'haaaa, 16'h5555});
         drain();
      end

      // Random phases, each under a new layout.
      for (int p = 0; p < 10; p++) begin
         apply_layout(p % 6);
         if (p == 9) quiet_phase = 1;
         for (int n = 0; n < RANDOM_ITEMS / 10; n++) begin
            w = random_sample();
            send_sample(w);
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
